@@ hw/rtl/sobel_pkg.sv @@
// Shared constants, register codes and types of the Sobel gradient filter.
package sobel_pkg;

	// Defaults of the top-level parameters.
	localparam int MAX_WIDTH_DEF  = 2048;
	localparam int MAX_HEIGHT_DEF = 2048;
	localparam int PIXEL_BITS_DEF = 16;

	// Field widths fixed by the register map and the result format.
	localparam int POS_W     = 11;
	localparam int CFG_W     = 12;
	localparam int CFG_IDX_W = 2;
	// Wide enough for the largest frame size plus one.
	localparam int CMP_W     = 14;

	// Register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_DIRECTION = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_HEIGHT    = 2'd2;

	// Register reset values.
	localparam logic [CFG_W-1:0] WIDTH_RST  = 12'd640;
	localparam logic [CFG_W-1:0] HEIGHT_RST = 12'd480;

	// Gradient direction codes.
	localparam logic DIR_X = 1'b0;
	localparam logic DIR_Y = 1'b1;

	// Result slots of one pixel, in emission order.
	localparam int NUM_SLOTS = 4;
	localparam logic [1:0] SLOT_PREV_LEFT = 2'd0;
	localparam logic [1:0] SLOT_PREV_HERE = 2'd1;
	localparam logic [1:0] SLOT_CURR_LEFT = 2'd2;
	localparam logic [1:0] SLOT_CURR_HERE = 2'd3;

	// Control of one result bundle handed to the emitter.
	typedef struct packed {
		logic [NUM_SLOTS-1:0] mask;
		logic                 row_ge1;
		logic                 row_ge2;
	} bundle_ctrl_t;

endpackage

@@ hw/rtl/sobel_3x3_gradient_filter.sv @@
// Top level of the streaming 3x3 Sobel gradient filter.
//
// Pixels enter in raster order on the in_valid / in_ready channel, one
// transaction per pixel. Each pixel releases zero to four gradient results
// on the out_valid / out_ready channel; last_of_run marks the final result
// that a pixel releases. The result for pixel (r,c) appears once pixel
// (r+1,c+1) has arrived, the last column of a row follows with the last
// pixel of the next row, and the pixels of the last row also flush that
// row. Frame edges are replicated.
// An input transaction is registered in stage one, then in the result
// bundle, then in the output register. Throughput is one result per cycle
// while the receiver is ready, set by the single shared Sobel unit and
// output register. The line memories take one read and one write each
// cycle at different columns.
// Configuration is written through cfg_write / cfg_index / cfg_data while
// the block is idle. Reset restores x mode, 640 by 480 and the start of a
// frame; the line memories need no clearing. When the receiver stalls, the
// pending result holds, one more pixel and one bundle are kept, and then
// in_ready drops.
module sobel_3x3_gradient_filter #(
	parameter int MAX_WIDTH  = sobel_pkg::MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = sobel_pkg::MAX_HEIGHT_DEF,
	parameter int PIXEL_BITS = sobel_pkg::PIXEL_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_write,
	input  logic [sobel_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [sobel_pkg::CFG_W-1:0]         cfg_data,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [PIXEL_BITS-1:0]               pixel,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic signed [PIXEL_BITS+2:0]        gradient,
	output logic [sobel_pkg::POS_W-1:0]         out_row,
	output logic [sobel_pkg::POS_W-1:0]         out_col,
	output logic                                last_of_run
);

	localparam int CW    = $clog2(MAX_WIDTH);
	localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
	localparam int CMP_W = sobel_pkg::CMP_W;
	localparam int POS_W = sobel_pkg::POS_W;

	// Configuration registers.
	logic                        cfg_dir_q;
	logic [sobel_pkg::CFG_W-1:0] cfg_width_q;
	logic [sobel_pkg::CFG_W-1:0] cfg_height_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_dir_q    <= sobel_pkg::DIR_X;
			cfg_width_q  <= sobel_pkg::WIDTH_RST;
			cfg_height_q <= sobel_pkg::HEIGHT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				sobel_pkg::REG_DIRECTION: cfg_dir_q    <= cfg_data[0];
				sobel_pkg::REG_WIDTH:     cfg_width_q  <= cfg_data;
				sobel_pkg::REG_HEIGHT:    cfg_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// Frame size as used, clamped into the supported range.
	logic [CMP_W-1:0] eff_w;
	logic [CMP_W-1:0] eff_h;

	always_comb begin
		eff_w = CMP_W'(cfg_width_q);
		if (eff_w < CMP_W'(2)) begin
			eff_w = CMP_W'(2);
		end else if (eff_w > CMP_W'(MAX_WIDTH)) begin
			eff_w = CMP_W'(MAX_WIDTH);
		end
		eff_h = CMP_W'(cfg_height_q);
		if (eff_h < CMP_W'(1)) begin
			eff_h = CMP_W'(1);
		end else if (eff_h > CMP_W'(MAX_HEIGHT)) begin
			eff_h = CMP_W'(MAX_HEIGHT);
		end
	end

	// Position of the next pixel. A counter at or past a shrunken size
	// counts as the last column or row, so the frame closes there.
	logic [CW-1:0] col_q;
	logic [RW-1:0] row_q;
	logic          in_accept;
	logic          lastcol;
	logic          lastrow;
	logic [sobel_pkg::NUM_SLOTS-1:0] mask_c;

	assign in_accept = in_valid && in_ready;
	assign lastcol   = (CMP_W'(col_q) + CMP_W'(1)) >= eff_w;
	assign lastrow   = (CMP_W'(row_q) + CMP_W'(1)) >= eff_h;

	// Which of the four results this pixel releases, in emission order:
	// the previous row left and here, then the last row left and here.
	always_comb begin
		mask_c[sobel_pkg::SLOT_PREV_LEFT] = (row_q != '0) && (col_q != '0);
		mask_c[sobel_pkg::SLOT_PREV_HERE] = (row_q != '0) && lastcol;
		mask_c[sobel_pkg::SLOT_CURR_LEFT] = lastrow && (col_q != '0);
		mask_c[sobel_pkg::SLOT_CURR_HERE] = lastrow && lastcol;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_accept) begin
			if (lastcol) begin
				col_q <= '0;
				row_q <= lastrow ? '0 : row_q + RW'(1);
			end else begin
				col_q <= col_q + CW'(1);
			end
		end
	end

	// Stage one: the pixel waits here while its column of the two line
	// memories is read.
	logic                            s1_valid_q;
	logic [PIXEL_BITS-1:0]           pixel_s1;
	logic [CW-1:0]                   idx_s1;
	logic [POS_W-1:0]                row_s1;
	logic [POS_W-1:0]                col_s1;
	logic [sobel_pkg::NUM_SLOTS-1:0] mask_s1;
	logic                            ge1_s1;
	logic                            ge2_s1;
	logic                            col1_s1;
	logic                            take_ready;
	logic                            s1_adv;

	assign s1_adv   = s1_valid_q && take_ready;
	assign in_ready = !s1_valid_q || take_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (in_accept) begin
			s1_valid_q <= 1'b1;
		end else if (s1_adv) begin
			s1_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_accept) begin
			pixel_s1 <= pixel;
			idx_s1   <= col_q;
			row_s1   <= POS_W'(row_q);
			col_s1   <= POS_W'(col_q);
			mask_s1  <= mask_c;
			ge1_s1   <= row_q != '0;
			ge2_s1   <= CMP_W'(row_q) >= CMP_W'(2);
			col1_s1  <= CMP_W'(col_q) == CMP_W'(1);
		end
	end

	// Line memories: read at acceptance, rotated and written back when the
	// pixel leaves stage one.
	logic [PIXEL_BITS-1:0] rd_older;
	logic [PIXEL_BITS-1:0] rd_middle;

	sobel_line_buffer #(
		.PIXEL_BITS (PIXEL_BITS),
		.DEPTH      (MAX_WIDTH)
	) u_line_buffer (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd_en     (in_accept),
		.rd_addr   (col_q),
		.rd_older  (rd_older),
		.rd_middle (rd_middle),
		.wr_en     (s1_adv),
		.wr_addr   (idx_s1),
		.wr_older  (rd_middle),
		.wr_middle (pixel_s1)
	);

	// Column window: three columns of (older, middle, current) rows.
	logic [PIXEL_BITS-1:0] win_q [9];
	logic [PIXEL_BITS-1:0] wa [3];
	logic [PIXEL_BITS-1:0] wb [3];
	logic [PIXEL_BITS-1:0] wc [3];
	logic [PIXEL_BITS-1:0] wl [3];

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			wa[i] = win_q[3 + i];
			wb[i] = win_q[6 + i];
			// In the second column the left neighbor is replicated.
			wl[i] = col1_s1 ? win_q[6 + i] : win_q[3 + i];
		end
		wc[0] = rd_older;
		wc[1] = rd_middle;
		wc[2] = pixel_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < 9; i++) begin
				win_q[i] <= '0;
			end
		end else if (s1_adv) begin
			for (int i = 0; i < 3; i++) begin
				win_q[i]     <= wa[i];
				win_q[3 + i] <= wb[i];
				win_q[6 + i] <= wc[i];
			end
		end
	end

	// Hand the snapshot to the emitter when the pixel releases results.
	sobel_pkg::bundle_ctrl_t load_ctrl;
	logic                    load;

	assign load              = s1_adv && (mask_s1 != '0);
	assign load_ctrl.mask    = mask_s1;
	assign load_ctrl.row_ge1 = ge1_s1;
	assign load_ctrl.row_ge2 = ge2_s1;

	sobel_emitter #(
		.PIXEL_BITS (PIXEL_BITS)
	) u_emitter (
		.clk          (clk),
		.arst_n       (arst_n),
		.direction    (cfg_dir_q),
		.load         (load),
		.load_ctrl    (load_ctrl),
		.load_row     (row_s1),
		.load_col     (col_s1),
		.load_lcol    (wl),
		.load_bcol    (wb),
		.load_ccol    (wc),
		.take_ready   (take_ready),
		.res_valid    (out_valid),
		.res_ready    (out_ready),
		.res_gradient (gradient),
		.res_row      (out_row),
		.res_col      (out_col),
		.res_last     (last_of_run)
	);

	// An accepted pixel always lands in stage one.
	a_s1_fill: assert property (@(posedge clk) disable iff (!arst_n)
		in_accept |=> s1_valid_q)
		else $error("accepted pixel did not reach stage one");

	// A pixel held in stage one keeps its column while the read data waits.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && !take_ready |=> s1_valid_q && $stable(idx_s1))
		else $error("stalled pixel lost its column");

endmodule

@@ hw/rtl/sobel_line_buffer.sv @@
// Two row memories holding the older and the middle row of the window.
module sobel_line_buffer #(
	parameter int PIXEL_BITS = sobel_pkg::PIXEL_BITS_DEF,
	parameter int DEPTH      = sobel_pkg::MAX_WIDTH_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [PIXEL_BITS-1:0]    rd_older,
	output logic [PIXEL_BITS-1:0]    rd_middle,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [PIXEL_BITS-1:0]    wr_older,
	input  logic [PIXEL_BITS-1:0]    wr_middle
);

	logic [PIXEL_BITS-1:0] older_mem  [DEPTH];
	logic [PIXEL_BITS-1:0] middle_mem [DEPTH];
	logic [PIXEL_BITS-1:0] rd_older_q;
	logic [PIXEL_BITS-1:0] rd_middle_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			older_mem[wr_addr]  <= wr_older;
			middle_mem[wr_addr] <= wr_middle;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_older_q  <= older_mem[rd_addr];
			rd_middle_q <= middle_mem[rd_addr];
		end
	end

	assign rd_older  = rd_older_q;
	assign rd_middle = rd_middle_q;

	// The pipeline never reads a column in the cycle it is written back.
	a_no_collision: assert property (@(posedge clk) disable iff (!arst_n)
		rd_en && wr_en |-> rd_addr != wr_addr)
		else $error("line buffer read and write hit the same column");

endmodule

@@ hw/rtl/sobel_emitter.sv @@
// Result bundle, shared Sobel unit and output register.
module sobel_emitter #(
	parameter int PIXEL_BITS = sobel_pkg::PIXEL_BITS_DEF
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               direction,
	input  logic                               load,
	input  sobel_pkg::bundle_ctrl_t            load_ctrl,
	input  logic [sobel_pkg::POS_W-1:0]        load_row,
	input  logic [sobel_pkg::POS_W-1:0]        load_col,
	input  logic [PIXEL_BITS-1:0]              load_lcol [3],
	input  logic [PIXEL_BITS-1:0]              load_bcol [3],
	input  logic [PIXEL_BITS-1:0]              load_ccol [3],
	output logic                               take_ready,
	output logic                               res_valid,
	input  logic                               res_ready,
	output logic signed [PIXEL_BITS+2:0]       res_gradient,
	output logic [sobel_pkg::POS_W-1:0]        res_row,
	output logic [sobel_pkg::POS_W-1:0]        res_col,
	output logic                               res_last
);

	localparam int GW = PIXEL_BITS + 3;
	localparam int SW = PIXEL_BITS + 2;
	localparam int NS = sobel_pkg::NUM_SLOTS;

	logic                        bnd_valid_q;
	logic [NS-1:0]               mask_q;
	logic                        ge1_q;
	logic                        ge2_q;
	logic [sobel_pkg::POS_W-1:0] row_q;
	logic [sobel_pkg::POS_W-1:0] col_q;
	logic [PIXEL_BITS-1:0]       lcol_q [3];
	logic [PIXEL_BITS-1:0]       bcol_q [3];
	logic [PIXEL_BITS-1:0]       ccol_q [3];

	logic                        out_valid_q;
	logic signed [GW-1:0]        grad_q;
	logic [sobel_pkg::POS_W-1:0] orow_q;
	logic [sobel_pkg::POS_W-1:0] ocol_q;
	logic                        olast_q;

	logic [1:0]                  pick;
	logic [NS-1:0]               pick_bit;
	logic                        pick_last;
	logic                        emit;
	logic [PIXEL_BITS-1:0]       lc [3];
	logic [PIXEL_BITS-1:0]       cc [3];
	logic [PIXEL_BITS-1:0]       rc [3];
	logic [1:0]                  ti;
	logic [1:0]                  mi;
	logic [1:0]                  bi;
	logic [sobel_pkg::POS_W-1:0] sel_row;
	logic [sobel_pkg::POS_W-1:0] sel_col;
	logic [SW-1:0]               pos_sum;
	logic [SW-1:0]               neg_sum;
	logic signed [GW-1:0]        grad_c;

	// Lowest pending slot goes first.
	always_comb begin
		if (mask_q[0]) begin
			pick = sobel_pkg::SLOT_PREV_LEFT;
		end else if (mask_q[1]) begin
			pick = sobel_pkg::SLOT_PREV_HERE;
		end else if (mask_q[2]) begin
			pick = sobel_pkg::SLOT_CURR_LEFT;
		end else begin
			pick = sobel_pkg::SLOT_CURR_HERE;
		end
		pick_bit  = NS'(1) << pick;
		pick_last = (mask_q & ~pick_bit) == '0;
	end

	assign emit       = bnd_valid_q && (!out_valid_q || res_ready);
	assign take_ready = !bnd_valid_q || (emit && pick_last);

	// Window columns and kernel rows of the chosen slot.
	always_comb begin
		unique case (pick)
			sobel_pkg::SLOT_PREV_LEFT, sobel_pkg::SLOT_CURR_LEFT: begin
				lc = lcol_q;
				cc = bcol_q;
				rc = ccol_q;
				sel_col = col_q - sobel_pkg::POS_W'(1);
			end
			default: begin
				lc = bcol_q;
				cc = ccol_q;
				rc = ccol_q;
				sel_col = col_q;
			end
		endcase
		if (pick == sobel_pkg::SLOT_PREV_LEFT || pick == sobel_pkg::SLOT_PREV_HERE) begin
			ti = ge2_q ? 2'd0 : 2'd1;
			mi = 2'd1;
			bi = 2'd2;
			sel_row = row_q - sobel_pkg::POS_W'(1);
		end else begin
			ti = ge1_q ? 2'd1 : 2'd2;
			mi = 2'd2;
			bi = 2'd2;
			sel_row = row_q;
		end
	end

	always_comb begin
		if (direction == sobel_pkg::DIR_X) begin
			pos_sum = SW'(lc[ti]) + (SW'(lc[mi]) << 1) + SW'(lc[bi]);
			neg_sum = SW'(rc[ti]) + (SW'(rc[mi]) << 1) + SW'(rc[bi]);
		end else begin
			pos_sum = SW'(lc[ti]) + (SW'(cc[ti]) << 1) + SW'(rc[ti]);
			neg_sum = SW'(lc[bi]) + (SW'(cc[bi]) << 1) + SW'(rc[bi]);
		end
		grad_c = $signed(GW'(pos_sum)) - $signed(GW'(neg_sum));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bnd_valid_q <= 1'b0;
			mask_q      <= '0;
		end else if (load) begin
			bnd_valid_q <= 1'b1;
			mask_q      <= load_ctrl.mask;
		end else if (emit) begin
			bnd_valid_q <= !pick_last;
			mask_q      <= mask_q & ~pick_bit;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			ge1_q  <= load_ctrl.row_ge1;
			ge2_q  <= load_ctrl.row_ge2;
			row_q  <= load_row;
			col_q  <= load_col;
			lcol_q <= load_lcol;
			bcol_q <= load_bcol;
			ccol_q <= load_ccol;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (res_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			grad_q  <= grad_c;
			orow_q  <= sel_row;
			ocol_q  <= sel_col;
			olast_q <= pick_last;
		end
	end

	assign res_valid    = out_valid_q;
	assign res_gradient = grad_q;
	assign res_row      = orow_q;
	assign res_col      = ocol_q;
	assign res_last     = olast_q;

	// A held bundle always has a result left to send.
	a_bundle_pending: assert property (@(posedge clk) disable iff (!arst_n)
		bnd_valid_q |-> mask_q != '0)
		else $error("result bundle held with no pending slot");

	// A new bundle only replaces one that finishes in the same cycle.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		load |-> !bnd_valid_q || (emit && pick_last))
		else $error("result bundle overwritten before it was drained");

endmodule

@@ tb/sobel_3x3_gradient_filter_test.sv @@
`timescale 1ns / 100ps
// Self-checking testbench of the 3x3 Sobel gradient filter: directed table, random frames.
module sobel_3x3_gradient_filter_test;

	localparam int PIX_W = sobel_pkg::PIXEL_BITS_DEF;
	localparam int GRAD_W = PIX_W + 3;
	localparam int LINE_MAX = sobel_pkg::MAX_WIDTH_DEF;
	localparam int ROWS_MAX = sobel_pkg::MAX_HEIGHT_DEF;
	localparam int POS_W = sobel_pkg::POS_W;
	localparam int CFG_W = sobel_pkg::CFG_W;
	localparam int CFG_IDX_W = sobel_pkg::CFG_IDX_W;

	// Idle time allowed after the last owed result and before a register write, so that
	// nothing is still in flight.
	localparam int SETTLE_CYCLES = 6;
	// Length of the one deliberate receiver stall, in cycles.
	localparam int HOLD_CYCLES = 300;
	// The longest correct quiet stretch is the receiver stall above; the limit is
	// several times that.
	localparam int IDLE_LIMIT = 3000;

	// One gradient result as the block presents it.
	typedef struct {
		logic signed [GRAD_W-1:0] grad;
		logic [POS_W-1:0]         row;
		logic [POS_W-1:0]         col;
		logic                     last;
	} gradient_t;

	// One row of the directed stimulus table. A pixel row with n_typed at zero or above
	// carries a hand-written expectation: that many results, each with gradient grad_typed.
	typedef enum logic {STEP_CFG, STEP_PIXEL} step_kind_t;
	typedef struct {
		step_kind_t           kind;
		logic [CFG_IDX_W-1:0] index;
		int                   value;
		int                   n_typed;
		int                   grad_typed;
	} plan_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_write = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [PIX_W-1:0] pixel = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [GRAD_W-1:0] gradient;
	logic [POS_W-1:0] out_row;
	logic [POS_W-1:0] out_col;
	logic last_of_run;

	always #5 clk = ~clk;

	sobel_3x3_gradient_filter DUT (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_write(cfg_write),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.pixel(pixel),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.gradient(gradient),
		.out_row(out_row),
		.out_col(out_col),
		.last_of_run(last_of_run)
	);

	// Gradients still owed by the block, oldest first.
	gradient_t pending_gradients[$];
	plan_row_t plan[$];
	int errors = 0;
	int idle_cycles = 0;
	// Set by the stimulus to ask for the long receiver stall; cleared by the receiver.
	bit stall_req = 1'b0;
	// Random gaps between pixel transactions are on unless a phase wants a dense stream.
	bit gaps_on = 1'b1;

	// Shadow of the filter: registers, line stores, 3x3 window and raster position.
	logic dir_cfg = sobel_pkg::DIR_X;
	logic [CFG_W-1:0] width_cfg = sobel_pkg::WIDTH_RST;
	logic [CFG_W-1:0] height_cfg = sobel_pkg::HEIGHT_RST;
	logic [PIX_W-1:0] older_line[LINE_MAX];
	logic [PIX_W-1:0] middle_line[LINE_MAX];
	// Three columns of three rows: base 0 is the oldest column, base 6 the newest. Within a
	// column, offset 0 is the row two back, 1 the row above and 2 the current row.
	logic [PIX_W-1:0] win[9];
	int unsigned row_pos = 0;
	int unsigned col_pos = 0;

	initial begin
		for (int i = 0; i < LINE_MAX; i++) begin
			older_line[i] = '0;
			middle_line[i] = '0;
		end
		for (int i = 0; i < 9; i++) win[i] = '0;
	end

	// The weighted sum for one output pixel. lb, cb and rb are the window bases of the
	// left, centre and right columns; t, m and b pick the top, middle and bottom rows.
	// Edge replication is done by the caller through the choice of bases and offsets.
	function automatic int sobel_sum(int lb, int cb, int rb, int t, int m, int b);
		int g;
		if (dir_cfg == sobel_pkg::DIR_X) begin
			g = (int'(win[lb+t]) - int'(win[rb+t]))
				+ 2 * (int'(win[lb+m]) - int'(win[rb+m]))
				+ (int'(win[lb+b]) - int'(win[rb+b]));
		end else begin
			g = (int'(win[lb+t]) + 2 * int'(win[cb+t]) + int'(win[rb+t]))
				- (int'(win[lb+b]) + 2 * int'(win[cb+b]) + int'(win[rb+b]));
		end
		return g;
	endfunction

	function automatic gradient_t make_gradient(int g, int unsigned r, int unsigned c);
		gradient_t res;
		res.grad = g[GRAD_W-1:0];
		res.row = r[POS_W-1:0];
		res.col = c[POS_W-1:0];
		res.last = 1'b0;
		return res;
	endfunction

	// Advances the shadow by one accepted pixel and queues the gradients it releases.
	task automatic predict_pixel(input logic [PIX_W-1:0] p, input int n_typed,
			input int grad_typed);
		gradient_t res[4];
		int n;
		int unsigned w;
		int unsigned h;
		int unsigned idx;
		int t;
		int lb;
		bit lastcol;
		bit lastrow;
		w = width_cfg;
		h = height_cfg;
		// Sizes outside the supported range act as the nearest supported one.
		if (w < 2) w = 2;
		if (w > LINE_MAX) w = LINE_MAX;
		if (h < 1) h = 1;
		if (h > ROWS_MAX) h = ROWS_MAX;
		idx = (col_pos < LINE_MAX) ? col_pos : LINE_MAX - 1;

		for (int i = 0; i < 6; i++) win[i] = win[i+3];
		win[6] = older_line[idx];
		win[7] = middle_line[idx];
		win[8] = p;
		older_line[idx] = middle_line[idx];
		middle_line[idx] = p;

		lastcol = (col_pos + 1 >= w);
		lastrow = (row_pos + 1 >= h);
		n = 0;
		// In column 1 the missing left neighbour of column 0 is column 0 itself.
		lb = (col_pos == 1) ? 3 : 0;

		// The row above is complete once this pixel is in; near the top edge the row above
		// it is replaced by itself.
		if (row_pos >= 1) begin
			t = (row_pos >= 2) ? 0 : 1;
			if (col_pos >= 1) begin
				res[n] = make_gradient(sobel_sum(lb, 3, 6, t, 1, 2), row_pos - 1, col_pos - 1);
				n++;
			end
			if (lastcol) begin
				res[n] = make_gradient(sobel_sum(3, 6, 6, t, 1, 2), row_pos - 1, col_pos);
				n++;
			end
		end
		// On the last row the current row is flushed too, its own row standing in below.
		if (lastrow) begin
			t = (row_pos >= 1) ? 1 : 2;
			if (col_pos >= 1) begin
				res[n] = make_gradient(sobel_sum(lb, 3, 6, t, 2, 2), row_pos, col_pos - 1);
				n++;
			end
			if (lastcol) begin
				res[n] = make_gradient(sobel_sum(3, 6, 6, t, 2, 2), row_pos, col_pos);
				n++;
			end
		end

		// A hand-written expectation from the table takes the place of the computed values.
		if (n_typed >= 0) begin
			if (n_typed != n) begin
				errors++;
				$display("%0t: result count mismatch: expected %0d, predicted %0d",
					$time, n_typed, n);
			end
			for (int i = 0; i < n; i++) res[i].grad = grad_typed[GRAD_W-1:0];
		end
		if (n > 0) res[n-1].last = 1'b1;
		for (int i = 0; i < n; i++) pending_gradients.push_back(res[i]);

		if (lastcol) begin
			col_pos = 0;
			row_pos = lastrow ? 0 : row_pos + 1;
		end else begin
			col_pos = col_pos + 1;
		end
	endtask

	// Result checker and watchdog. Outputs are sampled at the rising edge, before the
	// block's own updates of that edge land.
	always @(posedge clk) begin
		gradient_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_gradients.size() == 0) begin
					errors++;
					$display("%0t: unexpected result: expected none, got gradient %0d",
						$time, gradient);
					$display("%0t:   row %0d col %0d last %0b",
						$time, out_row, out_col, last_of_run);
				end else begin
					want = pending_gradients.pop_front();
					if ({want.grad, want.row, want.col, want.last}
							!== {gradient, out_row, out_col, last_of_run}) begin
						errors++;
						$display("%0t: result mismatch: expected gradient %0d row %0d",
							$time, want.grad, want.row);
						$display("%0t:   col %0d last %0b, got gradient %0d row %0d",
							$time, want.col, want.last, gradient, out_row);
						$display("%0t:   col %0d last %0b",
							$time, out_col, last_of_run);
					end
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_write)
				idle_cycles = 0;
			else
				idle_cycles = idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("tb: failure");
				$finish;
			end
		end
	end

	// Receiver: random stretches of ready and of stall, mostly short, sometimes long, and
	// once on request a long hold-off counted here.
	initial begin
		int seg_left;
		int r;
		logic seg_ready;
		seg_left = 0;
		seg_ready = 1'b0;
		forever begin
			@(negedge clk);
			if (stall_req) begin
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES - 1) @(negedge clk);
				stall_req = 1'b0;
				seg_left = 0;
			end else begin
				if (seg_left == 0) begin
					r = $urandom_range(0, 99);
					if (r < 55) begin
						seg_ready = 1'b1;
						seg_left = $urandom_range(1, 24);
					end else if (r < 60) begin
						seg_ready = 1'b1;
						seg_left = $urandom_range(100, 300);
					end else if (r < 95) begin
						seg_ready = 1'b0;
						seg_left = $urandom_range(1, 3);
					end else begin
						seg_ready = 1'b0;
						seg_left = $urandom_range(20, 60);
					end
				end
				seg_left--;
				out_ready <= seg_ready;
			end
		end
	end

	function automatic int pick_gap();
		int r;
		if (!gaps_on) return 0;
		r = $urandom_range(0, 99);
		if (r < 55) return 0;
		if (r < 93) return $urandom_range(1, 3);
		return $urandom_range(15, 60);
	endfunction

	// Pixels lean toward the extremes so that the largest gradients show up often.
	function automatic logic [PIX_W-1:0] pick_pixel();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0) return '0;
		if (r == 1) return '1;
		return PIX_W'($urandom);
	endfunction

	// All stimulus tasks start and end at a falling edge, where inputs change. valid stays
	// high across back-to-back transactions and is only lowered for a gap or a drain.
	task automatic send_pixel(input logic [PIX_W-1:0] p, input int n_typed,
			input int grad_typed);
		int gap;
		gap = pick_gap();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		pixel <= p;
		do @(posedge clk); while (!in_ready);
		predict_pixel(p, n_typed, grad_typed);
		@(negedge clk);
	endtask

	// Stops offering pixels until every owed gradient has come out, then lets the
	// pipeline settle.
	task automatic wait_drained();
		in_valid <= 1'b0;
		while (pending_gradients.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		@(negedge clk);
	endtask

	// Registers are only written with the block idle.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_W-1:0] data);
		wait_drained();
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		case (idx)
			sobel_pkg::REG_DIRECTION: dir_cfg = data[0];
			sobel_pkg::REG_WIDTH: width_cfg = data;
			sobel_pkg::REG_HEIGHT: height_cfg = data;
			default: ;
		endcase
		@(negedge clk);
		cfg_write <= 1'b0;
	endtask

	function automatic int unsigned clamp_size(int unsigned v, int unsigned lo,
			int unsigned hi);
		if (v < lo) return lo;
		if (v > hi) return hi;
		return v;
	endfunction

	// A pause in the middle of a frame, followed by a change that keeps every line store
	// read within what this frame has written: a new direction, a new height, or a width
	// no larger than the current one. A counter past a new size closes the frame early.
	task automatic change_mid_frame();
		logic [CFG_W-1:0] d;
		case ($urandom_range(0, 2))
			0: begin
				d = CFG_W'($urandom);
				d[0] = ~dir_cfg;
				write_reg(sobel_pkg::REG_DIRECTION, d);
			end
			1: write_reg(sobel_pkg::REG_HEIGHT, CFG_W'($urandom_range(0, height_cfg)));
			default: write_reg(sobel_pkg::REG_WIDTH,
				CFG_W'($urandom_range(0, clamp_size(width_cfg, 2, LINE_MAX))));
		endcase
	endtask

	// One whole frame of random pixels. It ends when the shadow position is back at the
	// start of a frame, which also covers frames closed early by a mid-frame change.
	task automatic random_frame(input int w, input int h, input logic dir,
			input bit may_pause, input bit hold_receiver);
		logic [CFG_W-1:0] d;
		int total;
		int pause_at;
		int sent;
		d = CFG_W'($urandom);
		d[0] = dir;
		write_reg(sobel_pkg::REG_DIRECTION, d);
		write_reg(sobel_pkg::REG_WIDTH, CFG_W'(w));
		write_reg(sobel_pkg::REG_HEIGHT, CFG_W'(h));
		total = clamp_size(w, 2, LINE_MAX) * clamp_size(h, 1, ROWS_MAX);
		pause_at = (may_pause && $urandom_range(0, 2) == 0)
			? $urandom_range(1, total - 1) : -1;
		if (hold_receiver) stall_req = 1'b1;
		sent = 0;
		do begin
			if (sent == pause_at) change_mid_frame();
			send_pixel(pick_pixel(), -1, 0);
			sent++;
		end while (row_pos != 0 || col_pos != 0);
	endtask

	task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx, input int v);
		plan_row_t r;
		r.kind = STEP_CFG;
		r.index = idx;
		r.value = v;
		r.n_typed = -1;
		r.grad_typed = 0;
		plan.push_back(r);
	endtask

	task automatic add_pix(input int v, input int n_typed, input int grad_typed);
		plan_row_t r;
		r.kind = STEP_PIXEL;
		r.index = sobel_pkg::REG_DIRECTION;
		r.value = v;
		r.n_typed = n_typed;
		r.grad_typed = grad_typed;
		plan.push_back(r);
	endtask

	initial begin
		// Out of reset the frame is 640 by 480 in x mode, and the first pixels of a row
		// release nothing.
		add_pix(65535, 0, 0);
		add_pix(0, 0, 0);
		// Shrinking the frame mid-row: the column counter is already past width 2 and row 0
		// is now the last row, so the next pixel closes the frame.
		add_cfg(sobel_pkg::REG_HEIGHT, 1);
		add_cfg(sobel_pkg::REG_WIDTH, 2);
		add_pix(4660, -1, 0);
		// Two-pixel single-row frames: with both edges replicated, each result is four
		// times left minus right, which reaches both ends of the gradient range.
		add_pix(65535, 0, 0);
		add_pix(0, 2, 262140);
		add_pix(0, 0, 0);
		add_pix(65535, 2, -262140);
		// A single row has no vertical gradient.
		add_cfg(sobel_pkg::REG_DIRECTION, sobel_pkg::DIR_Y);
		add_pix(65535, 0, 0);
		add_pix(0, 2, 0);
		// Width 0 acts as 2 and height 0 as 1.
		add_cfg(sobel_pkg::REG_DIRECTION, sobel_pkg::DIR_X);
		add_cfg(sobel_pkg::REG_WIDTH, 0);
		add_cfg(sobel_pkg::REG_HEIGHT, 0);
		add_pix(0, 0, 0);
		add_pix(65535, 2, -262140);
		// A 3 by 3 checkerboard in y mode covers every edge and corner replication.
		add_cfg(sobel_pkg::REG_DIRECTION, sobel_pkg::DIR_Y);
		add_cfg(sobel_pkg::REG_WIDTH, 3);
		add_cfg(sobel_pkg::REG_HEIGHT, 3);
		for (int i = 0; i < 9; i++) add_pix((i % 2 == 1) ? 65535 : 0, -1, 0);
		// Smallest two-row frame in x mode.
		add_cfg(sobel_pkg::REG_DIRECTION, sobel_pkg::DIR_X);
		add_cfg(sobel_pkg::REG_WIDTH, 2);
		add_cfg(sobel_pkg::REG_HEIGHT, 2);
		add_pix(65535, -1, 0);
		add_pix(0, -1, 0);
		add_pix(0, -1, 0);
		add_pix(65535, -1, 0);
		// Sizes above the range act as the largest ones, so a row of four pixels stays
		// open; shrinking both sizes then closes the frame at the next pixel.
		add_cfg(sobel_pkg::REG_WIDTH, 4095);
		add_cfg(sobel_pkg::REG_HEIGHT, 4095);
		add_pix(65535, 0, 0);
		add_pix(1000, 0, 0);
		add_pix(0, 0, 0);
		add_pix(30000, 0, 0);
		add_cfg(sobel_pkg::REG_HEIGHT, 1);
		add_cfg(sobel_pkg::REG_WIDTH, 2);
		add_pix(777, -1, 0);

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (plan[i]) begin
			if (plan[i].kind == STEP_CFG)
				write_reg(plan[i].index, CFG_W'(plan[i].value));
			else
				send_pixel(PIX_W'(plan[i].value), plan[i].n_typed, plan[i].grad_typed);
		end

		// Small random frames, now and then with a mid-frame pause and change. Sizes 0 and 1
		// show up as well, since they act as the smallest legal sizes.
		for (int f = 0; f < 8; f++) begin
			gaps_on = ($urandom_range(0, 3) != 0);
			random_frame(($urandom_range(0, 9) == 0)
					? $urandom_range(0, 1) : $urandom_range(2, 9),
				$urandom_range(0, 6), $urandom_range(0, 1), 1'b1, 1'b0);
		end

		// Dense stream into a stalled receiver, so the block fills and drops in_ready.
		gaps_on = 1'b0;
		random_frame(8, 6, $urandom_range(0, 1), 1'b0, 1'b1);

		gaps_on = 1'b1;
		random_frame($urandom_range(2, 6), $urandom_range(2, 5), $urandom_range(0, 1),
			1'b1, 1'b0);

		wait_drained();
		repeat (20) @(posedge clk);
		if (pending_gradients.size() != 0) begin
			errors++;
			$display("%0t: %0d results never arrived", $time, pending_gradients.size());
		end
		if (errors == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
